// ----- sv/oshb_pkg.sv -----
// shared types and constants for the overwriting sample history buffer
// no dependencies; imported by the controller, the datapath and the top level
package oshb_pkg;

    // default ring depth in entries
    localparam int DEPTH_DEF = 64;

    // field widths fixed by the interface
    localparam int DATA_W = 16;
    localparam int NFEAT  = 6;
    localparam int SAMP_W = DATA_W * NFEAT;
    localparam int CMD_W  = 3;
    localparam int AMT_W  = 7;
    localparam int FILL_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ_IDX = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_OLD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_NEW = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic push;       // write sample at head
        logic clear;      // empty the ring
        logic load_old;   // load read address from oldest pointer
        logic add_amt;    // with load_old: offset by amount
        logic load_new;   // load read address as head minus amount
        logic step;       // read one entry and advance the address
        logic emit_zero;  // single result with no data
        logic err;        // status bit of that result
        logic last;       // last bit of a burst result
    } t_ctl;

    // status from the datapath to the controller
    typedef struct packed {
        logic [FILL_W-1:0] fill_cnt;
    } t_sts;

endpackage

// ----- sv/oshb_ctrl.sv -----
// controller: command decode, range checks and burst sequencing
// depends on oshb_pkg
module oshb_ctrl import oshb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [AMT_W-1:0] i_amount,
    input  t_sts             i_sts,
    output logic             busy,
    output t_ctl             o_ctl
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_BURST = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [AMT_W-1:0] r_left;
    logic [AMT_W-1:0] n_left;
    logic             accept;
    logic             amt_zero;
    logic             idx_over;
    logic             cnt_over;

    assign busy     = (r_state == ST_BURST);
    assign accept   = start && (r_state == ST_IDLE);
    assign amt_zero = (i_amount == '0);
    assign idx_over = (i_amount >= i_sts.fill_cnt);
    assign cnt_over = (i_amount > i_sts.fill_cnt);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_PUSH: begin
                            o_ctl.push      = 1'b1;
                            o_ctl.emit_zero = 1'b1;
                        end
                        CMD_CLEAR: begin
                            o_ctl.clear     = 1'b1;
                            o_ctl.emit_zero = 1'b1;
                        end
                        CMD_READ_IDX: begin
                            if (idx_over) begin
                                o_ctl.emit_zero = 1'b1;
                                o_ctl.err       = 1'b1;
                            end else begin
                                o_ctl.load_old = 1'b1;
                                o_ctl.add_amt  = 1'b1;
                                n_left         = AMT_W'(1);
                                n_state        = ST_BURST;
                            end
                        end
                        CMD_READ_OLD: begin
                            if (cnt_over) begin
                                o_ctl.emit_zero = 1'b1;
                                o_ctl.err       = 1'b1;
                            end else if (!amt_zero) begin
                                o_ctl.load_old = 1'b1;
                                n_left         = i_amount;
                                n_state        = ST_BURST;
                            end
                        end
                        CMD_READ_NEW: begin
                            if (cnt_over) begin
                                o_ctl.emit_zero = 1'b1;
                                o_ctl.err       = 1'b1;
                            end else if (!amt_zero) begin
                                o_ctl.load_new = 1'b1;
                                n_left         = i_amount;
                                n_state        = ST_BURST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BURST: begin
                o_ctl.step = 1'b1;
                o_ctl.last = (r_left == AMT_W'(1));
                n_left     = r_left - AMT_W'(1);
                if (r_left == AMT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

endmodule

// ----- sv/oshb_dpath.sv -----
// datapath: sample memory, ring pointers, fill count and result registers
// depends on oshb_pkg
module oshb_dpath import oshb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [SAMP_W-1:0] i_sample,
    input  logic [AMT_W-1:0]  i_amount,
    output t_sts              o_sts,
    output logic              o_strobe,
    output logic [SAMP_W-1:0] o_data,
    output logic              o_status,
    output logic              o_last,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_full_res
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [SAMP_W-1:0] mem [DEPTH];

    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     n_wp;
    logic [PW-1:0]     r_old;
    logic [PW-1:0]     n_old;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [PW-1:0]     r_addr;
    logic [PW-1:0]     n_addr;
    logic [SAMP_W-1:0] r_rd_data;
    logic              r_o_valid;
    logic              r_o_read;
    logic              r_o_status;
    logic              r_o_last;
    logic [FILL_W-1:0] r_o_fill;

    logic              full;
    logic [PW:0]       amt_ofs;
    logic [PW:0]       sum_old;
    logic [PW+1:0]     sum_new;
    logic [PW-1:0]     start_old;
    logic [PW-1:0]     start_new;

    assign full           = (r_count == CW'(DEPTH));
    assign o_sts.fill_cnt = FILL_W'(r_count);

    // burst start addresses, each sum stays below twice the depth
    assign amt_ofs = i_amount[PW:0];
    assign sum_old = {1'b0, r_old} + (i_ctl.add_amt ? amt_ofs : '0);
    assign sum_new = {2'b00, r_wp} + (PW+2)'(DEPTH) - {1'b0, amt_ofs};

    always_comb begin
        if (sum_old >= (PW+1)'(DEPTH)) begin
            start_old = PW'(sum_old - (PW+1)'(DEPTH));
        end else begin
            start_old = sum_old[PW-1:0];
        end
        if (sum_new >= (PW+2)'(DEPTH)) begin
            start_new = PW'(sum_new - (PW+2)'(DEPTH));
        end else begin
            start_new = sum_new[PW-1:0];
        end
    end

    // pointer, count and read address updates
    always_comb begin
        n_wp    = r_wp;
        n_old   = r_old;
        n_count = r_count;
        n_addr  = r_addr;
        priority if (i_ctl.push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (full) begin
                n_old = (r_old == PW'(DEPTH - 1)) ? '0 : r_old + PW'(1);
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (i_ctl.clear) begin
            n_wp    = '0;
            n_old   = '0;
            n_count = '0;
        end else if (i_ctl.load_old) begin
            n_addr = start_old;
        end else if (i_ctl.load_new) begin
            n_addr = start_new;
        end else if (i_ctl.step) begin
            n_addr = (r_addr == PW'(DEPTH - 1)) ? '0 : r_addr + PW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_old     <= '0;
            r_count   <= '0;
            r_addr    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_old     <= n_old;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_o_valid <= i_ctl.emit_zero || i_ctl.step;
        end
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_wp] <= i_sample;
        end
        if (i_ctl.step) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_o_read   <= i_ctl.step;
        r_o_status <= i_ctl.err;
        r_o_last   <= i_ctl.emit_zero || i_ctl.last;
        r_o_fill   <= FILL_W'(n_count);
    end

    assign o_strobe     = r_o_valid;
    assign o_data       = r_o_read ? r_rd_data : '0;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;
    assign o_fill_count = r_o_fill;
    assign o_full_res   = (r_o_fill == FILL_W'(DEPTH));

endmodule

// ----- sv/overwriting_sample_history_buffer_unit.sv -----
// top level of the overwriting sample history buffer
// depends on oshb_pkg, oshb_ctrl and oshb_dpath
//
// usage:
//   a command (push, read by index, read oldest n, read newest n, clear) is
//   taken at a rising edge with start high and busy low. results come out on
//   the o_ ports for one cycle each, marked by o_strobe; o_last flags the
//   final result of a command. the receiver cannot stall the block, so every
//   strobed result is a transfer.
// command flow:
//   push, clear and out-of-range requests give one result in the cycle after
//   the command; busy stays low, so one such command per cycle.
//   a read of n entries keeps busy high while one entry a cycle goes through
//   the single read port of the sample memory; the read address is loaded
//   first, then each entry passes the registered read port to the o_ ports.
//   a burst with n of zero and unknown codes give no result.
// reset:
//   synchronous, active low; empties the ring, memory contents are left as is
//   and no clearing pass is needed.
module overwriting_sample_history_buffer_unit import oshb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_acc_x,
    input  logic signed [DATA_W-1:0] i_acc_y,
    input  logic signed [DATA_W-1:0] i_acc_z,
    input  logic signed [DATA_W-1:0] i_gyro_x,
    input  logic signed [DATA_W-1:0] i_gyro_y,
    input  logic signed [DATA_W-1:0] i_gyro_z,
    input  logic [AMT_W-1:0]         i_amount,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_rd_acc_x,
    output logic signed [DATA_W-1:0] o_rd_acc_y,
    output logic signed [DATA_W-1:0] o_rd_acc_z,
    output logic signed [DATA_W-1:0] o_rd_gyro_x,
    output logic signed [DATA_W-1:0] o_rd_gyro_y,
    output logic signed [DATA_W-1:0] o_rd_gyro_z,
    output logic                     o_status,
    output logic                     o_last,
    output logic [FILL_W-1:0]        o_fill_count,
    output logic                     o_full_res
);

    t_ctl              ctl;
    t_sts              sts;
    logic [SAMP_W-1:0] sample;
    logic [SAMP_W-1:0] rd_data;

    // pack the six axes into one memory word
    assign sample = {i_gyro_z, i_gyro_y, i_gyro_x, i_acc_z, i_acc_y, i_acc_x};

    oshb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_amount (i_amount),
        .i_sts    (sts),
        .busy     (busy),
        .o_ctl    (ctl)
    );

    oshb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_sample     (sample),
        .i_amount     (i_amount),
        .o_sts        (sts),
        .o_strobe     (o_strobe),
        .o_data       (rd_data),
        .o_status     (o_status),
        .o_last       (o_last),
        .o_fill_count (o_fill_count),
        .o_full_res   (o_full_res)
    );

    // unpack the entry read
    assign o_rd_acc_x  = rd_data[1*DATA_W-1:0*DATA_W];
    assign o_rd_acc_y  = rd_data[2*DATA_W-1:1*DATA_W];
    assign o_rd_acc_z  = rd_data[3*DATA_W-1:2*DATA_W];
    assign o_rd_gyro_x = rd_data[4*DATA_W-1:3*DATA_W];
    assign o_rd_gyro_y = rd_data[5*DATA_W-1:4*DATA_W];
    assign o_rd_gyro_z = rd_data[6*DATA_W-1:5*DATA_W];

endmodule

// ----- sim/overwriting_sample_history_buffer_unit_tb.sv -----
// self-checking testbench for overwriting_sample_history_buffer_unit
// depends on oshb_pkg and the rtl under sv/; a directed table first, then random traffic
`timescale 1ns / 1ps

module overwriting_sample_history_buffer_unit_tb import oshb_pkg::*; ();

    localparam int HALF_PERIOD = 5;
    localparam int RST_CYCLES  = 7;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = DEPTH_DEF + 8;
    localparam int ITEM_TARGET = 350;

    // codes the block does not decode
    localparam logic [CMD_W-1:0] CMD_UNDEF_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_7 = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] ax, ay, az, gx, gy, gz;
    } t_sample;

    typedef struct packed {
        t_sample           data;
        logic              status;
        logic              last;
        logic [FILL_W-1:0] fill;
        logic              full;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        t_sample           data;
        logic [AMT_W-1:0]  amt;
        logic              typed;   // expected result written in the table
        logic              status;
        logic [FILL_W-1:0] fill;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  i_cmd;
    t_sample           drv_samp;
    logic [AMT_W-1:0]  i_amount;
    logic              o_strobe;
    logic [DATA_W-1:0] o_rd_acc_x, o_rd_acc_y, o_rd_acc_z;
    logic [DATA_W-1:0] o_rd_gyro_x, o_rd_gyro_y, o_rd_gyro_z;
    logic              o_status;
    logic              o_last;
    logic [FILL_W-1:0] o_fill_count;
    logic              o_full_res;

    // row currently offered, as seen by the monitor
    logic              cur_typed;
    logic              cur_status;
    logic [FILL_W-1:0] cur_fill;

    // ring predictor state
    t_sample hist_ring [DEPTH_DEF];
    int      hist_wr;
    int      hist_old;
    int      hist_held;

    t_result awaited_results [$];
    t_row    dir_rows [$];
    int      n_taken;
    int      n_errors;
    int      quiet_cycles;
    int      n_items;
    bit      gaps_on;
    bit      drained_once;

    overwriting_sample_history_buffer_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_acc_x      (drv_samp.ax),
        .i_acc_y      (drv_samp.ay),
        .i_acc_z      (drv_samp.az),
        .i_gyro_x     (drv_samp.gx),
        .i_gyro_y     (drv_samp.gy),
        .i_gyro_z     (drv_samp.gz),
        .i_amount     (i_amount),
        .o_strobe     (o_strobe),
        .o_rd_acc_x   (o_rd_acc_x),
        .o_rd_acc_y   (o_rd_acc_y),
        .o_rd_acc_z   (o_rd_acc_z),
        .o_rd_gyro_x  (o_rd_gyro_x),
        .o_rd_gyro_y  (o_rd_gyro_y),
        .o_rd_gyro_z  (o_rd_gyro_z),
        .o_status     (o_status),
        .o_last       (o_last),
        .o_fill_count (o_fill_count),
        .o_full_res   (o_full_res)
    );

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_sample mk_sample(logic [DATA_W-1:0] ax, logic [DATA_W-1:0] ay,
                                          logic [DATA_W-1:0] az, logic [DATA_W-1:0] gx,
                                          logic [DATA_W-1:0] gy, logic [DATA_W-1:0] gz);
        t_sample s;
        s = '{ax, ay, az, gx, gy, gz};
        return s;
    endfunction

    // sensor code with extra weight on the extremes
    function automatic logic [DATA_W-1:0] rand_code();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 15))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return r[DATA_W-1:0];
        endcase
    endfunction

    function automatic t_sample rand_sample();
        return mk_sample(rand_code(), rand_code(), rand_code(),
                         rand_code(), rand_code(), rand_code());
    endfunction

    function automatic t_row dir_row(logic [CMD_W-1:0] cmd, t_sample data, logic [AMT_W-1:0] amt,
                                     logic typed, logic status, logic [FILL_W-1:0] fill);
        t_row r;
        r = '{cmd, data, amt, typed, status, fill};
        return r;
    endfunction

    task automatic await_result(t_sample data, logic status, logic last);
        t_result r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        r.fill   = hist_held[FILL_W-1:0];
        r.full   = (hist_held == DEPTH_DEF);
        awaited_results.push_back(r);
    endtask

    // ring predictor: updates state and queues the results one command causes
    task automatic history_apply(logic [CMD_W-1:0] cmd, t_sample s, logic [AMT_W-1:0] amt);
        int n;
        int base;
        n = int'(amt);
        case (cmd)
            CMD_PUSH: begin
                hist_ring[hist_wr] = s;
                hist_wr = (hist_wr + 1) % DEPTH_DEF;
                if (hist_held < DEPTH_DEF) hist_held++;
                else hist_old = (hist_old + 1) % DEPTH_DEF;
                await_result('0, 1'b0, 1'b1);
            end
            CMD_READ_IDX: begin
                if (n >= hist_held) await_result('0, 1'b1, 1'b1);
                else await_result(hist_ring[(hist_old + n) % DEPTH_DEF], 1'b0, 1'b1);
            end
            CMD_READ_OLD, CMD_READ_NEW: begin
                if (n > hist_held) begin
                    await_result('0, 1'b1, 1'b1);
                end else if (n > 0) begin
                    base = (cmd == CMD_READ_OLD) ? hist_old
                                                 : (hist_wr + DEPTH_DEF - n) % DEPTH_DEF;
                    for (int i = 0; i < n; i++)
                        await_result(hist_ring[(base + i) % DEPTH_DEF], 1'b0, i == n - 1);
                end
            end
            CMD_CLEAR: begin
                hist_wr   = 0;
                hist_old  = 0;
                hist_held = 0;
                await_result('0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // monitor: result transfers first, then the command transfer of this edge
    always @(posedge i_clk) begin
        t_result want;
        int      prev_size;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if ($isunknown({busy, o_strobe})) begin
                $display("%0t: unknown on busy/strobe, expected 0/1, got %b/%b",
                         $time, busy, o_strobe);
                n_errors++;
            end
            if (o_strobe === 1'b1) begin
                moved = 1'b1;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result transfer, expected none, got fill %0d status %b",
                             $time, o_fill_count, o_status);
                    n_errors++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("rd_acc_x",   want.data.ax, o_rd_acc_x);
                    compare_field("rd_acc_y",   want.data.ay, o_rd_acc_y);
                    compare_field("rd_acc_z",   want.data.az, o_rd_acc_z);
                    compare_field("rd_gyro_x",  want.data.gx, o_rd_gyro_x);
                    compare_field("rd_gyro_y",  want.data.gy, o_rd_gyro_y);
                    compare_field("rd_gyro_z",  want.data.gz, o_rd_gyro_z);
                    compare_field("status",     DATA_W'(want.status), DATA_W'(o_status));
                    compare_field("last",       DATA_W'(want.last),   DATA_W'(o_last));
                    compare_field("fill_count", DATA_W'(want.fill),   DATA_W'(o_fill_count));
                    compare_field("full_res",   DATA_W'(want.full),   DATA_W'(o_full_res));
                end
            end
            if (start && busy === 1'b0) begin
                moved     = 1'b1;
                prev_size = awaited_results.size();
                history_apply(i_cmd, drv_samp, i_amount);
                // table rows with a written result replace the predicted one
                if (cur_typed) begin
                    while (awaited_results.size() > prev_size)
                        void'(awaited_results.pop_back());
                    want.data   = '0;
                    want.status = cur_status;
                    want.last   = 1'b1;
                    want.fill   = cur_fill;
                    want.full   = (cur_fill == DEPTH_DEF);
                    awaited_results.push_back(want);
                end
                n_taken <= n_taken + 1;
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("overwriting_sample_history_buffer_unit_tb: done, errors");
            $finish;
        end
    end

    // offer one command and hold it until its transfer
    task automatic send_cmd(logic [CMD_W-1:0] cmd, t_sample s, logic [AMT_W-1:0] amt,
                            logic typed, logic status, logic [FILL_W-1:0] fill);
        int seen;
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 14) begin
                start    = 1'b0;
                i_cmd    = CMD_W'($urandom_range(0, 7));
                drv_samp = rand_sample();
                i_amount = AMT_W'($urandom_range(0, 127));
                @(negedge i_clk);
            end
        end
        start      = 1'b1;
        i_cmd      = cmd;
        drv_samp   = s;
        i_amount   = amt;
        cur_typed  = typed;
        cur_status = status;
        cur_fill   = fill;
        seen = n_taken;
        do @(negedge i_clk); while (n_taken == seen);
        if (cmd <= CMD_CLEAR && !((cmd == CMD_READ_OLD || cmd == CMD_READ_NEW) && amt == 0))
            n_items++;
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
    endtask

    // random read with mostly small amounts, a few that span the whole fill and out-of-range ones
    task automatic send_rand_read();
        int               r;
        logic [CMD_W-1:0] c;
        logic [AMT_W-1:0] a;
        r = $urandom_range(0, 99);
        c = CMD_W'($urandom_range(int'(CMD_READ_IDX), int'(CMD_READ_NEW)));
        if (r < 60)      a = AMT_W'($urandom_range(0, (hist_held < 8) ? hist_held : 8));
        else if (r < 75) a = AMT_W'($urandom_range(0, hist_held));
        else if (r < 82) a = AMT_W'(hist_held);
        else             a = AMT_W'($urandom_range(0, 127));
        send_cmd(c, rand_sample(), a, 1'b0, 1'b0, '0);
    endtask

    initial begin
        int pick;
        int run;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = CMD_PUSH;
        drv_samp   = '0;
        i_amount   = '0;
        cur_typed  = 1'b0;
        cur_status = 1'b0;
        cur_fill   = '0;
        hist_wr    = 0;
        hist_old   = 0;
        hist_held  = 0;
        n_taken    = 0;
        n_errors   = 0;
        quiet_cycles = 0;
        n_items    = 0;
        gaps_on    = 1'b1;
        drained_once = 1'b0;

        // directed table: empty ring, extremes, every command, error cases
        dir_rows.push_back(dir_row(CMD_READ_IDX, '0, 7'd0,   1'b1, 1'b1, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_OLD, '0, 7'd1,   1'b1, 1'b1, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_NEW, '0, 7'd0,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_OLD, '0, 7'd64,  1'b1, 1'b1, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_NEW, '0, 7'd127, 1'b1, 1'b1, 7'd0));
        dir_rows.push_back(dir_row(CMD_PUSH, {6{16'h7fff}}, 7'd127, 1'b1, 1'b0, 7'd1));
        dir_rows.push_back(dir_row(CMD_PUSH, {6{16'h8000}}, 7'd0,   1'b1, 1'b0, 7'd2));
        dir_rows.push_back(dir_row(CMD_PUSH, mk_sample(16'h0000, 16'hffff, 16'h7fff,
                                   16'h8000, 16'h0001, 16'h5555), 7'd64, 1'b1, 1'b0, 7'd3));
        dir_rows.push_back(dir_row(CMD_PUSH, mk_sample(16'haaaa, 16'h0001, 16'hfffe,
                                   16'h8001, 16'h7ffe, 16'h0000), 7'd3, 1'b1, 1'b0, 7'd4));
        dir_rows.push_back(dir_row(CMD_READ_IDX, '0, 7'd0,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_IDX, '0, 7'd3,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_IDX, '0, 7'd4,   1'b1, 1'b1, 7'd4));
        dir_rows.push_back(dir_row(CMD_READ_IDX, {6{16'hffff}}, 7'd127, 1'b1, 1'b1, 7'd4));
        dir_rows.push_back(dir_row(CMD_READ_OLD, '0, 7'd4,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_NEW, '0, 7'd2,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_OLD, '0, 7'd5,   1'b1, 1'b1, 7'd4));
        dir_rows.push_back(dir_row(CMD_READ_NEW, '0, 7'd5,   1'b1, 1'b1, 7'd4));
        dir_rows.push_back(dir_row(CMD_READ_OLD, '0, 7'd0,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_UNDEF_5,  '0, 7'd1,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_UNDEF_7, {6{16'hffff}}, 7'd127, 1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_UNDEF_6,  '0, 7'd2,   1'b0, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_CLEAR,    '0, 7'd9,   1'b1, 1'b0, 7'd0));
        dir_rows.push_back(dir_row(CMD_READ_NEW, '0, 7'd1,   1'b1, 1'b1, 7'd0));
        dir_rows.push_back(dir_row(CMD_PUSH, mk_sample(16'h1234, 16'hedcb, 16'h00ff,
                                   16'hff00, 16'h0f0f, 16'hf0f0), 7'd0, 1'b1, 1'b0, 7'd1));
        dir_rows.push_back(dir_row(CMD_READ_NEW, '0, 7'd1,   1'b0, 1'b0, 7'd0));

        // reset
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].amt,
                     dir_rows[i].typed, dir_rows[i].status, dir_rows[i].fill);

        // random part: push runs to fill and wrap the ring, reads, rare clears, noise
        while (n_items < ITEM_TARGET) begin
            gaps_on = !(n_items >= 200 && n_items < 280);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                run = $urandom_range(1, 24);
                repeat (run) send_cmd(CMD_PUSH, rand_sample(),
                                      AMT_W'($urandom_range(0, 127)), 1'b0, 1'b0, '0);
            end else if (pick < 85) begin
                send_rand_read();
            end else if (pick < 89) begin
                send_cmd(CMD_CLEAR, rand_sample(), AMT_W'($urandom_range(0, 127)),
                         1'b0, 1'b0, '0);
            end else begin
                send_cmd(CMD_W'($urandom_range(0, 7)), rand_sample(),
                         AMT_W'($urandom_range(0, 127)), 1'b0, 1'b0, '0);
            end
            // sender holds off once until the block has gone quiet
            if (!drained_once && n_items >= 170) begin
                drain_results();
                drained_once = 1'b1;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("overwriting_sample_history_buffer_unit_tb: done, clean");
        end else begin
            $display("overwriting_sample_history_buffer_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
